// ===== sv/rtqm_pkg.sv =====
// ============================================================================
// rtqm_pkg: shared widths and constants for the ratio-to-question-mark core
// Field widths of the channels and the fixed constants of the datapath.
// ============================================================================
package rtqm_pkg;

  // Width of numerator, denominator, integer part and cutoff
  localparam int unsigned DATA_W = 31;
  // Width of the fixed-point fraction (value is f / 2^FRAC_W)
  localparam int unsigned FRAC_W = 32;
  // Width of the term count field
  localparam int unsigned CNT_W = 6;
  // Number of iterations of the restoring divider
  localparam int unsigned DIV_STEPS = DATA_W;
  // Cutoff value after reset
  localparam logic [DATA_W-1:0] CUTOFF_RESET = 31'h7fff_ffff;

endpackage

// ===== sv/rtqm_if.sv =====
// ============================================================================
// rtqm_if: valid/ready channels of the ratio-to-question-mark core
// Input ratio channel, result channel and cutoff write channel.
// ============================================================================
interface rtqm_in_if;
  logic                        valid;
  logic                        ready;
  logic [rtqm_pkg::DATA_W-1:0] numerator;
  logic [rtqm_pkg::DATA_W-1:0] denominator;

  modport source (output valid, numerator, denominator, input ready);
  modport sink   (input valid, numerator, denominator, output ready);
endinterface

interface rtqm_out_if;
  logic                        valid;
  logic                        ready;
  logic [rtqm_pkg::DATA_W-1:0] integer_part;
  logic [rtqm_pkg::FRAC_W-1:0] question_mark_fraction;
  logic [rtqm_pkg::CNT_W-1:0]  term_count;
  logic                        divide_error;

  modport source (output valid, integer_part, question_mark_fraction, term_count,
                  divide_error, input ready);
  modport sink   (input valid, integer_part, question_mark_fraction, term_count,
                  divide_error, output ready);
endinterface

interface rtqm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rtqm_pkg::DATA_W-1:0] cutoff;

  modport source (output valid, cutoff, input ready);
  modport sink   (input valid, cutoff, output ready);
endinterface

// ===== sv/ratio_to_question_mark_core.sv =====
// ============================================================================
// ratio_to_question_mark_core: ratio to Minkowski question mark value
// Integer part of numerator/denominator and ?(x) of the fractional part as
// 32-bit fixed point, built from a continued-fraction expansion.
// ============================================================================
// Usage:
//   in_i  : one transaction carries numerator and denominator. in_i.ready is
//           high only while the core is idle; it works on one ratio at a time.
//   out_o : one result transaction per input transaction, in order. The
//           result sits in an output register, so the next ratio is taken
//           while the previous result waits for out_o.ready.
//   cfg_i : writes the cutoff register; always ready. Write it while idle.
// Sequence: a zero denominator goes straight to the hand-over. Otherwise an
//   integer division, then per continued-fraction term a division in the
//   shared restoring divider, a cutoff multiply and a check; then up to
//   three trailing terms are placed and the result is handed over. The
//   single shared divider does the integer and the term divisions.
// Reset: clears the sequencer and the output valid, sets cutoff to 0x7fffffff.
// Stall: a result not taken holds out_o; a finished ratio waits in the core
//   until the output register frees, and in_i.ready stays low meanwhile.
// ============================================================================
module ratio_to_question_mark_core #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtqm_cfg_if.sink    cfg_i,
  rtqm_in_if.sink     in_i,
  rtqm_out_if.source  out_o
);

  localparam int unsigned DW   = rtqm_pkg::DATA_W;
  localparam int unsigned FW   = rtqm_pkg::FRAC_W;
  localparam int unsigned TW   = FW;                         // term value width
  localparam int unsigned PW   = DW + TW;                    // product width
  localparam int unsigned IW   = $clog2(MAX_TERMS);          // term index width
  localparam int unsigned CW   = $clog2(MAX_TERMS + 1);      // count width
  localparam int unsigned DCW  = $clog2(rtqm_pkg::DIV_STEPS);
  localparam int unsigned POSW = $clog2(FW + 1) + 1;         // bit position width
  localparam int unsigned SHW  = $clog2(FW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_POST,
    S_CHECK,
    S_TAIL,
    S_DONE
  } state_e;

  // Control state
  state_e            state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [DW-1:0]     cutoff_q, cutoff_d;
  logic [DCW-1:0]    dcnt_q, dcnt_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [1:0]        tcnt_q, tcnt_d;
  logic              odd_q, odd_d;
  logic              first_q, first_d;
  logic              is_int_q, is_int_d;
  logic [POSW-1:0]   pos_q, pos_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  // Datapath
  logic [DW-1:0]     quot_q, quot_d;
  logic [DW-1:0]     prem_q, prem_d;
  logic [DW-1:0]     dsor_q, dsor_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic [TW-1:0]     pend_q, pend_d;
  logic [TW-1:0]     tail_q [3];
  logic [TW-1:0]     tail_d [3];
  logic [DW-1:0]     ip_q, ip_d;
  logic [FW-1:0]     frac_q, frac_d;
  logic              err_q, err_d;
  logic [DW-1:0]     out_ip_q, out_ip_d;
  logic [FW-1:0]     out_frac_q, out_frac_d;
  logic [CW-1:0]     out_cnt_q, out_cnt_d;
  logic              out_err_q, out_err_d;

  // Combinational helpers
  logic [DW-1:0]     cut_w;
  logic [DW+1:0]     trial;
  logic              trial_ge;
  logic [DW:0]       rem_p1;
  logic [TW-1:0]     m_w;
  logic              clamp;
  logic              emit_en;
  logic [TW-1:0]     emit_val;
  logic [TW-1:0]     run_len;
  logic [POSW-1:0]   pos_sum;
  logic [POSW-1:0]   pos_end;
  logic [CW+rtqm_pkg::CNT_W-1:0] cnt_wide;

  // Ones from bit position x (MSB first) down to bit 0; empty at FW
  function automatic logic [FW-1:0] ones_from(input logic [POSW-1:0] x);
    logic [FW-1:0] r;
    if (x >= POSW'(FW)) begin
      r = '0;
    end else begin
      r = {FW{1'b1}} >> x[SHW-1:0];
    end
    return r;
  endfunction

  assign cut_w    = (cutoff_q == '0) ? DW'(1) : cutoff_q;
  assign trial    = {1'b0, prem_q, quot_q[DW-1]} - {2'b00, dsor_q};
  assign trial_ge = ~trial[DW+1];
  assign rem_p1   = {1'b0, prem_q} + (DW+1)'(1);
  assign m_w      = TW'(quot_q);
  // remainder clamps when floor(d / cut) > rem, i.e. (rem + 1) * cut <= d
  assign clamp    = (prod_q <= PW'(dsor_q));

  // Run length of the term being placed; the first term is one less
  assign run_len  = first_q ? (emit_val - TW'(1)) : emit_val;
  assign pos_sum  = pos_q + POSW'(run_len[SHW-1:0]);
  assign pos_end  = ((|run_len[TW-1:SHW]) || (pos_sum >= POSW'(FW))) ? POSW'(FW) : pos_sum;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    cutoff_d    = cfg_i.valid ? cfg_i.cutoff : cutoff_q;
    dcnt_d      = dcnt_q;
    idx_d       = idx_q;
    tcnt_d      = tcnt_q;
    odd_d       = odd_q;
    first_d     = first_q;
    is_int_d    = is_int_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    quot_d      = quot_q;
    prem_d      = prem_q;
    dsor_d      = dsor_q;
    prod_d      = prod_q;
    pend_d      = pend_q;
    tail_d      = tail_q;
    ip_d        = ip_q;
    frac_d      = frac_q;
    err_d       = err_q;
    out_ip_d    = out_ip_q;
    out_frac_d  = out_frac_q;
    out_cnt_d   = out_cnt_q;
    out_err_d   = out_err_q;
    emit_en     = 1'b0;
    emit_val    = pend_q;

    case (state_q)
      // Take a ratio and start the integer division
      S_IDLE: begin
        if (in_i.valid) begin
          ip_d     = '0;
          frac_d   = '0;
          cnt_d    = '0;
          pos_d    = '0;
          odd_d    = 1'b0;
          first_d  = 1'b1;
          idx_d    = '0;
          tcnt_d   = '0;
          err_d    = (in_i.denominator == '0);
          quot_d   = in_i.numerator;
          dsor_d   = in_i.denominator;
          prem_d   = '0;
          dcnt_d   = '0;
          is_int_d = 1'b1;
          state_d  = (in_i.denominator == '0) ? S_DONE : S_DIV;
        end
      end

      // One restoring division step per cycle
      S_DIV: begin
        prem_d = trial_ge ? trial[DW-1:0] : {prem_q[DW-2:0], quot_q[DW-1]};
        quot_d = {quot_q[DW-2:0], trial_ge};
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(rtqm_pkg::DIV_STEPS - 1)) begin
          state_d = S_POST;
        end
      end

      // Take the quotient: integer part, or one continued-fraction term
      S_POST: begin
        if (is_int_q) begin
          ip_d = quot_q;
          if (prem_q == '0) begin
            state_d = S_DONE;
          end else begin
            quot_d   = dsor_q;
            dsor_d   = prem_q;
            prem_d   = '0;
            dcnt_d   = '0;
            is_int_d = 1'b0;
            state_d  = S_DIV;
          end
        end else begin
          prod_d  = rem_p1 * cut_w;
          state_d = S_CHECK;
        end
      end

      // Apply the cutoff rule and decide how the expansion ends
      S_CHECK: begin
        if (clamp && (quot_q == DW'(1))) begin
          if (idx_q == '0) begin
            // leading term of one folds into the integer part
            ip_d    = ip_q + DW'(1);
            state_d = S_DONE;
          end else if (!idx_q[0]) begin
            tail_d[0] = pend_q + TW'(1);
            tcnt_d    = 2'd1;
            state_d   = S_TAIL;
          end else begin
            tail_d[0] = pend_q;
            tail_d[1] = TW'(1);
            tcnt_d    = 2'd2;
            state_d   = S_TAIL;
          end
        end else if (clamp || (prem_q == '0)) begin
          if (!idx_q[0]) begin
            // pad to even length: last term less one, then a one
            if (idx_q == '0) begin
              tail_d[0] = m_w - TW'(1);
              tail_d[1] = TW'(1);
              tcnt_d    = 2'd2;
            end else begin
              tail_d[0] = pend_q;
              tail_d[1] = m_w - TW'(1);
              tail_d[2] = TW'(1);
              tcnt_d    = 2'd3;
            end
          end else begin
            tail_d[0] = pend_q;
            tail_d[1] = m_w;
            tcnt_d    = 2'd2;
          end
          state_d = S_TAIL;
        end else if (idx_q == IW'(MAX_TERMS - 1)) begin
          // expansion cut short: no padding
          tail_d[0] = pend_q;
          tail_d[1] = m_w;
          tcnt_d    = 2'd2;
          state_d   = S_TAIL;
        end else begin
          // place the held term, hold this one, divide again
          emit_en  = (idx_q != '0);
          emit_val = pend_q;
          pend_d   = m_w;
          idx_d    = idx_q + IW'(1);
          quot_d   = dsor_q;
          dsor_d   = prem_q;
          prem_d   = '0;
          dcnt_d   = '0;
          state_d  = S_DIV;
        end
      end

      // Place the trailing terms one per cycle
      S_TAIL: begin
        if (tcnt_q == 2'd0) begin
          state_d = S_DONE;
        end else begin
          emit_en   = 1'b1;
          emit_val  = tail_q[0];
          tail_d[0] = tail_q[1];
          tail_d[1] = tail_q[2];
          tcnt_d    = tcnt_q - 2'd1;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_ip_d    = ip_q;
          out_frac_d  = frac_q;
          out_cnt_d   = cnt_q;
          out_err_d   = err_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Turn one term into a run of bits; odd terms are runs of ones
    if (emit_en) begin
      if (odd_q) begin
        frac_d = frac_q | (ones_from(pos_q) & ~ones_from(pos_end));
      end
      pos_d   = pos_end;
      odd_d   = ~odd_q;
      first_d = 1'b0;
      cnt_d   = (cnt_q == CW'(MAX_TERMS)) ? cnt_q : cnt_q + CW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cutoff_q    <= rtqm_pkg::CUTOFF_RESET;
      dcnt_q      <= '0;
      idx_q       <= '0;
      tcnt_q      <= '0;
      odd_q       <= 1'b0;
      first_q     <= 1'b1;
      is_int_q    <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cutoff_q    <= cutoff_d;
      dcnt_q      <= dcnt_d;
      idx_q       <= idx_d;
      tcnt_q      <= tcnt_d;
      odd_q       <= odd_d;
      first_q     <= first_d;
      is_int_q    <= is_int_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    quot_q     <= quot_d;
    prem_q     <= prem_d;
    dsor_q     <= dsor_d;
    prod_q     <= prod_d;
    pend_q     <= pend_d;
    tail_q     <= tail_d;
    ip_q       <= ip_d;
    frac_q     <= frac_d;
    err_q      <= err_d;
    out_ip_q   <= out_ip_d;
    out_frac_q <= out_frac_d;
    out_cnt_q  <= out_cnt_d;
    out_err_q  <= out_err_d;
  end

  // Drive the result channel; the count keeps its low six bits
  assign cnt_wide                     = (CW + rtqm_pkg::CNT_W)'(out_cnt_q);
  assign out_o.valid                  = out_valid_q;
  assign out_o.integer_part           = out_ip_q;
  assign out_o.question_mark_fraction = out_frac_q;
  assign out_o.term_count             = cnt_wide[rtqm_pkg::CNT_W-1:0];
  assign out_o.divide_error           = out_err_q;

endmodule
